>>> hw/rtl/vtp_pkg.sv
`default_nettype none
package vtp_pkg;

    localparam int unsigned CoefW    = 16;
    localparam int unsigned CoordW   = 16;
    localparam int unsigned RowW     = 48;
    localparam int unsigned OffW     = 32;
    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned QuoW     = 26;
    localparam int unsigned RemW     = 15;
    localparam int unsigned ProdW    = 32;

    localparam logic [QuoW-1:0] InvOne   = 26'h2000000;
    localparam logic [16:0]     ScaleX   = 17'h1999a;
    localparam logic [16:0]     ScaleY   = 17'h1e000;
    localparam logic [15:0]     CenterX  = 16'h0140;
    localparam logic [15:0]     CenterY  = 16'h00f0;

    localparam logic [CfgIdxW-1:0] RegRow0 = 3'd0;
    localparam logic [CfgIdxW-1:0] RegRow1 = 3'd1;
    localparam logic [CfgIdxW-1:0] RegRow2 = 3'd2;
    localparam logic [CfgIdxW-1:0] RegOffX = 3'd3;
    localparam logic [CfgIdxW-1:0] RegOffY = 3'd4;
    localparam logic [CfgIdxW-1:0] RegOffZ = 3'd5;

    typedef struct packed {
        logic [1:0]               slot;
        logic signed [CoordW-1:0] wx;
        logic signed [CoordW-1:0] wy;
        logic signed [CoordW-1:0] wz;
        logic                     pos;
        logic [RemW-1:0]          dvs;
        logic [RemW-1:0]          rem;
        logic [QuoW-1:0]          quo;
    } div_stage_t;

endpackage
`default_nettype wire

>>> hw/rtl/vertex_transform_project_unit.sv
`default_nettype none
// Vertex transform and perspective projection, one word per clock while the output is not stalled.
// Each vertex goes through a 3x3 4.12 matrix and a translation, then a
// divide of 0x2000000 by world z and two projection multiplies. The pipeline
// has one multiply stage, one row-sum stage, 26 stages of the pipelined
// restoring divider (one quotient bit each), and two projection multiply
// stages, the last of which is the output register. The whole
// pipeline advances together; a stall on the output holds every stage.
// Configuration writes are always taken (ready is tied high).
module vertex_transform_project_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [47:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  slot,
    input  wire logic signed [15:0] in_x,
    input  wire logic signed [15:0] in_y,
    input  wire logic signed [15:0] in_z,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       slot_out,
    output logic signed [15:0] world_x,
    output logic signed [15:0] world_y,
    output logic signed [15:0] world_z,
    output logic signed [15:0] screen_x,
    output logic signed [15:0] screen_y
);

    localparam int unsigned NDiv = vtp_pkg::QuoW;

    logic [vtp_pkg::RowW-1:0] row_reg [3];
    logic [vtp_pkg::OffW-1:0] off_reg [3];

    logic adv;

    // Stage 1: the nine coefficient products.
    logic                            s1_valid_reg;
    logic [1:0]                      s1_slot_reg;
    logic signed [vtp_pkg::ProdW-1:0] prod_reg [9];

    logic                div_valid_reg [NDiv+1];
    vtp_pkg::div_stage_t div_reg [NDiv+1];
    vtp_pkg::div_stage_t div_step_next [NDiv];
    vtp_pkg::div_stage_t s2_next;

    // Projection stage 1.
    logic                     p1_valid_reg;
    logic [1:0]               p1_slot_reg;
    logic signed [15:0]       p1_wx_reg, p1_wy_reg, p1_wz_reg;
    logic signed [15:0]       p1_tx_reg, p1_ty_reg;

    logic [vtp_pkg::QuoW-1:0] inv_fin;
    logic signed [31:0]       px_full, py_full;
    logic signed [32:0]       sx_full, sy_full;

    assign cfg_ready = 1'b1;
    assign adv       = !out_valid || !out_stall;
    assign in_stall  = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                row_reg[i] <= '0;
                off_reg[i] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                vtp_pkg::RegRow0: row_reg[0] <= cfg_data;
                vtp_pkg::RegRow1: row_reg[1] <= cfg_data;
                vtp_pkg::RegRow2: row_reg[2] <= cfg_data;
                vtp_pkg::RegOffX: off_reg[0] <= cfg_data[vtp_pkg::OffW-1:0];
                vtp_pkg::RegOffY: off_reg[1] <= cfg_data[vtp_pkg::OffW-1:0];
                vtp_pkg::RegOffZ: off_reg[2] <= cfg_data[vtp_pkg::OffW-1:0];
                default: ;
            endcase
        end
    end

    function automatic logic signed [15:0] coef(input logic [47:0] row, input int k);
        coef = $signed(row[16*k +: 16]);
    endfunction

    function automatic logic [15:0] row_sum(input logic signed [31:0] a,
                                            input logic signed [31:0] b,
                                            input logic signed [31:0] c,
                                            input logic [31:0] off);
        logic [31:0] s;
        s = 32'(a) + 32'(b) + 32'(c);
        // Low 16 bits of (s >>> 12) + off.
        row_sum = s[27:12] + off[15:0];
    endfunction

    function automatic vtp_pkg::div_stage_t div_step(input vtp_pkg::div_stage_t s,
                                                     input int k);
        vtp_pkg::div_stage_t o;
        logic [vtp_pkg::RemW:0] sh;
        logic [vtp_pkg::RemW:0] df;
        o  = s;
        // Only the top dividend bit is set, so it enters on the first step.
        sh = {s.rem, (k == 0) ? 1'b1 : 1'b0};
        df = sh - {1'b0, s.dvs};
        if (!df[vtp_pkg::RemW])
        begin
            o.rem = df[vtp_pkg::RemW-1:0];
            o.quo[vtp_pkg::QuoW-1-k] = 1'b1;
        end
        else
        begin
            o.rem = sh[vtp_pkg::RemW-1:0];
        end
        div_step = o;
    endfunction

    always_comb
    begin
        s2_next       = '0;
        s2_next.slot  = s1_slot_reg;
        s2_next.wx    = $signed(row_sum(prod_reg[0], prod_reg[1], prod_reg[2], off_reg[0]));
        s2_next.wy    = $signed(row_sum(prod_reg[3], prod_reg[4], prod_reg[5], off_reg[1]));
        s2_next.wz    = $signed(row_sum(prod_reg[6], prod_reg[7], prod_reg[8], off_reg[2]));
        s2_next.pos   = (s2_next.wz > 16'sd1);
        s2_next.dvs   = s2_next.pos ? s2_next.wz[vtp_pkg::RemW-1:0]
                                    : {{(vtp_pkg::RemW-1){1'b0}}, 1'b1};
    end

    always_comb
    begin
        for (int i = 0; i < NDiv; i++)
            div_step_next[i] = div_step(div_reg[i], i);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            p1_valid_reg <= 1'b0;
            out_valid    <= 1'b0;
            for (int i = 0; i <= NDiv; i++)
                div_valid_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
            p1_valid_reg <= div_valid_reg[NDiv];
            out_valid    <= p1_valid_reg;
            div_valid_reg[0] <= s1_valid_reg;
            for (int i = 0; i < NDiv; i++)
                div_valid_reg[i+1] <= div_valid_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_slot_reg <= slot;
            for (int r = 0; r < 3; r++)
            begin
                prod_reg[3*r]   <= coef(row_reg[r], 0) * in_x;
                prod_reg[3*r+1] <= coef(row_reg[r], 1) * in_y;
                prod_reg[3*r+2] <= coef(row_reg[r], 2) * in_z;
            end
            div_reg[0] <= s2_next;
            for (int i = 0; i < NDiv; i++)
                div_reg[i+1] <= div_step_next[i];
            p1_slot_reg <= div_reg[NDiv].slot;
            p1_wx_reg   <= div_reg[NDiv].wx;
            p1_wy_reg   <= div_reg[NDiv].wy;
            p1_wz_reg   <= div_reg[NDiv].wz;
            p1_tx_reg   <= px_full[31:16];
            p1_ty_reg   <= py_full[31:16];
            slot_out    <= p1_slot_reg;
            world_x     <= p1_wx_reg;
            world_y     <= p1_wy_reg;
            world_z     <= p1_wz_reg;
            screen_x    <= sx_full[31:16] + vtp_pkg::CenterX;
            screen_y    <= sy_full[31:16] + vtp_pkg::CenterY;
        end
    end

    always_comb
    begin
        inv_fin = div_reg[NDiv].pos ? div_reg[NDiv].quo : vtp_pkg::InvOne;
        px_full = $signed({6'b0, inv_fin}) * 32'(div_reg[NDiv].wx);
        py_full = $signed({6'b0, inv_fin}) * 32'(div_reg[NDiv].wy);
        sx_full = $signed({1'b0, vtp_pkg::ScaleX}) * p1_tx_reg;
        sy_full = $signed({1'b0, vtp_pkg::ScaleY}) * p1_ty_reg;
    end

endmodule
`default_nettype wire

>>> sim/tb_vertex_transform_project_unit.sv
`timescale 1ns / 100ps
module tb_vertex_transform_project_unit;

    typedef struct packed {
        logic [1:0]  slot;
        logic [15:0] wx;
        logic [15:0] wy;
        logic [15:0] wz;
        logic [15:0] sx;
        logic [15:0] sy;
    } vertex_out_t;

    int unsigned mismatch_count = 0;

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("MISMATCH %s: got %h, want %h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    class vertex_scoreboard;
        logic [47:0] rows [3];
        logic [31:0] offs [3];
        vertex_out_t pending [$];

        function new();
            for (int i = 0; i < 3; i++)
            begin
                rows[i] = '0;
                offs[i] = '0;
            end
        endfunction

        function void write_reg(input logic [2:0] idx, input logic [47:0] data);
            if (idx <= vtp_pkg::RegRow2)
                rows[idx] = data;
            else if (idx <= vtp_pkg::RegOffZ)
                offs[idx - vtp_pkg::RegOffX] = data[31:0];
        endfunction

        function automatic logic [15:0] transform_row(input int r, input logic signed [15:0] x,
                                                      input logic signed [15:0] y,
                                                      input logic signed [15:0] z);
            logic signed [31:0] acc;
            acc = $signed(rows[r][15:0]) * x + $signed(rows[r][31:16]) * y
                + $signed(rows[r][47:32]) * z;
            acc = (acc >>> 12) + $signed(offs[r]);
            return acc[15:0];
        endfunction

        function automatic logic [15:0] project_axis(input logic signed [31:0] inv,
                                                     input logic signed [15:0] w,
                                                     input logic signed [31:0] scale,
                                                     input logic [15:0] center);
            logic signed [31:0] t;
            t = inv * 32'(w);
            t = t >>> 16;
            t = t * scale;
            t = t >>> 16;
            return t[15:0] + center;
        endfunction

        function void note_vertex(input logic [1:0] s, input logic signed [15:0] x,
                                  input logic signed [15:0] y, input logic signed [15:0] z);
            vertex_out_t e;
            logic signed [31:0] inv;
            e.slot = s;
            e.wx = transform_row(0, x, y, z);
            e.wy = transform_row(1, x, y, z);
            e.wz = transform_row(2, x, y, z);
            inv = 32'sh2000000;
            if ($signed(e.wz) > 16'sd1)
                inv = 32'sh2000000 / 32'($signed(e.wz));
            e.sx = project_axis(inv, e.wx, 32'sh1999a, 16'h0140);
            e.sy = project_axis(inv, e.wy, 32'sh1e000, 16'h00f0);
            pending.push_back(e);
        endfunction

        task check_vertex(input vertex_out_t got);
            vertex_out_t want;
            if (pending.size() == 0)
            begin
                report_mismatch("unexpected word", got.wx, 16'h0000);
                return;
            end
            want = pending.pop_front();
            if (got.slot != want.slot) report_mismatch("slot_out", 16'(got.slot), 16'(want.slot));
            if (got.wx != want.wx) report_mismatch("world_x", got.wx, want.wx);
            if (got.wy != want.wy) report_mismatch("world_y", got.wy, want.wy);
            if (got.wz != want.wz) report_mismatch("world_z", got.wz, want.wz);
            if (got.sx != want.sx) report_mismatch("screen_x", got.sx, want.sx);
            if (got.sy != want.sy) report_mismatch("screen_y", got.sy, want.sy);
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [47:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] slot = '0;
    logic signed [15:0] in_x = '0, in_y = '0, in_z = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [1:0] slot_out;
    logic signed [15:0] world_x, world_y, world_z, screen_x, screen_y;

    vertex_scoreboard board = new();
    bit calm_phase = 1'b0;

    vertex_transform_project_unit u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .slot(slot), .in_x(in_x), .in_y(in_y), .in_z(in_z),
        .out_valid(out_valid), .out_stall(out_stall),
        .slot_out(slot_out), .world_x(world_x), .world_y(world_y), .world_z(world_z),
        .screen_x(screen_x), .screen_y(screen_y)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // The receiver stalls at random, except during the calm phase.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_vertex({slot_out, world_x, world_y, world_z, screen_x, screen_y});
        out_stall <= !calm_phase && ($urandom_range(99) < 34);
    end

    // Leaves cfg_valid high; the caller drops it after its last write.
    task automatic write_cfg(input logic [2:0] idx, input logic [47:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.write_reg(idx, data);
    endtask

    task automatic send_vertex(input logic [1:0] s, input logic [15:0] x,
                               input logic [15:0] y, input logic [15:0] z);
        while (!calm_phase && $urandom_range(99) < 34)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        slot <= s;
        in_x <= x;
        in_y <= y;
        in_z <= z;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_vertex(s, x, y, z);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic logic [15:0] pick_coord();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'(int'($urandom_range(64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_coef();
        case ($urandom_range(4))
            0: return 16'h1000;
            1: return 16'(int'($urandom_range(8192)) - 4096);
            2: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic load_setting(input int kind);
        logic [47:0] r;
        for (int i = 0; i < 3; i++)
        begin
            case (kind)
                0: r = 48'h0000_0000_0000;
                1: r = 48'hffff_ffff_ffff;
                2: r = {16'h8000, 16'h7fff, 16'h8000};
                3: r = (i == 0) ? 48'h1000 : (i == 1) ? 48'h1000_0000 : 48'h1000_0000_0000;
                default: r = {pick_coef(), pick_coef(), pick_coef()};
            endcase
            write_cfg(vtp_pkg::RegRow0 + 3'(i), r);
        end
        for (int i = 0; i < 3; i++)
        begin
            case (kind)
                0: r = 48'(32'h7fffffff);
                1: r = 48'(32'h80000000);
                2: r = 48'(32'h0);
                3: r = (i == 2) ? 48'(32'd500) : 48'(32'(int'($urandom_range(200)) - 100));
                default: r = ($urandom_range(3) == 0) ? {16'h0, 32'($urandom)}
                                                     : 48'(32'(int'($urandom_range(4000)) - 1000));
            endcase
            write_cfg(vtp_pkg::RegOffX + 3'(i), r);
        end
        // An index past the last register must be ignored.
        write_cfg(vtp_pkg::RegOffZ + 3'd1 + 3'($urandom_range(1)),
                  {16'($urandom), 32'($urandom)});
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, every slot, and world z at zero, one, two and negative.
        load_setting(3);
        send_vertex(2'd0, 16'h0000, 16'h0000, 16'h0000);
        send_vertex(2'd1, 16'h7fff, 16'h7fff, 16'h7fff);
        send_vertex(2'd2, 16'h8000, 16'h8000, 16'h8000);
        send_vertex(2'd3, 16'hffff, 16'h0001, 16'hfe0c);
        send_vertex(2'd0, 16'd100, 16'd50, 16'hfe0d);
        send_vertex(2'd1, 16'd100, 16'hffce, 16'hfe0e);
        send_vertex(2'd2, 16'h7fff, 16'h8000, 16'h0001);
        send_vertex(2'd3, 16'h5555, 16'haaaa, 16'h7000);
        drain();
        for (int k = 0; k < 3; k++)
        begin
            load_setting(k);
            send_vertex(2'd0, 16'h7fff, 16'h8000, 16'h7fff);
            send_vertex(2'd3, 16'h8000, 16'h7fff, 16'h8000);
            send_vertex(2'd1, 16'haaaa, 16'h5555, 16'hffff);
            drain();
        end

        // Random phases, each with its own setting; one phase runs without idling.
        for (int p = 0; p < 9; p++)
        begin
            load_setting((p == 4) ? 3 : 4);
            calm_phase = (p == 2);
            for (int n = 0; n < 200; n++)
                send_vertex(2'($urandom), pick_coord(), pick_coord(), pick_coord());
            calm_phase = 1'b0;
            drain();
        end

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end
endmodule
